@@ rtl/pes_pkg.sv @@
// pes_pkg: shared types, constants and helpers of the postfix stack evaluator.
// No dependencies; compile first.
`default_nettype none

package pes_pkg;

    localparam int QW      = 48;   // Q32.16 word
    localparam int SYM_W   = 8;
    localparam int DEPTH_W = 5;

    typedef logic signed [QW-1:0] t_q;

    localparam t_q Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam t_q Q_MIN = {1'b1, {(QW-1){1'b0}}};

    localparam logic [SYM_W-1:0] SYM_ZERO   = 8'h30;  // '0'
    localparam logic [SYM_W-1:0] SYM_NINE   = 8'h39;  // '9'
    localparam logic [SYM_W-1:0] SYM_ADD    = 8'h2B;  // '+'
    localparam logic [SYM_W-1:0] SYM_SUB    = 8'h2D;  // '-'
    localparam logic [SYM_W-1:0] SYM_F      = 8'h66;  // 'f'
    localparam logic [SYM_W-1:0] SYM_G      = 8'h67;  // 'g'
    localparam logic [SYM_W-1:0] SYM_TRIPLE = 8'h68;  // 'h'

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DIGIT,
        OP_TRIPLE,
        OP_ADD,
        OP_SUB,
        OP_F,
        OP_G
    } t_op;

    // per-cycle command to each stack cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_UP,    // take the value from the cell above (push / new head)
        CELL_DN1,   // take the value one cell below (pop one)
        CELL_DN2    // take the value two cells below (pop two)
    } t_cell_op;

    typedef struct packed {
        logic               ok;
        t_q                 value;
        logic [DEPTH_W-1:0] depth_left;
    } t_res;

    typedef struct packed {
        logic done;
        logic sat;
        t_q   prod;
    } t_mul_res;

    // true when a widened sum does not fit the Q word
    function automatic logic q_ovf(input logic signed [QW+1:0] v);
        return (v > (QW+2)'(Q_MAX)) || (v < (QW+2)'(Q_MIN));
    endfunction

endpackage

`default_nettype wire

@@ rtl/pes_if.sv @@
// Valid/ready channel interfaces of the postfix stack evaluator:
// symbol input words and result words. Depends on pes_pkg.
`default_nettype none

interface pes_sym_if;
    import pes_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, symbol, last, input ready);
    modport sink   (input valid, symbol, last, output ready);
endinterface

interface pes_res_if;
    import pes_pkg::*;

    logic               valid;
    logic               ready;
    logic               ok;
    t_q                 value;
    logic [DEPTH_W-1:0] depth_left;

    modport source (output valid, ok, value, depth_left, input ready);
    modport sink   (input valid, ok, value, depth_left, output ready);
endinterface

`default_nettype wire

@@ rtl/pes_cell.sv @@
// pes_cell: one entry of the shift-register operand stack; loads from its
// upper or lower neighbors or holds. Depends on pes_pkg.
`default_nettype none

module pes_cell (
    input  logic               i_clk,
    input  pes_pkg::t_cell_op  i_op,
    input  pes_pkg::t_q        i_up,
    input  pes_pkg::t_q        i_dn1,
    input  pes_pkg::t_q        i_dn2,
    output pes_pkg::t_q        o_q
);
    import pes_pkg::*;

    t_q r_q;
    t_q n_q;

    always_comb begin
        case (i_op)
            CELL_UP:  n_q = i_up;
            CELL_DN1: n_q = i_dn1;
            CELL_DN2: n_q = i_dn2;
            default:  n_q = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

@@ rtl/pes_mulq.sv @@
// pes_mulq: iterative signed Q-format multiplier, one 24x24 partial product
// per cycle, then floor to FRAC_BITS and saturate. Depends on pes_pkg.
`default_nettype none

module pes_mulq #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pes_pkg::t_q       i_x,
    input  pes_pkg::t_q       i_y,
    output pes_pkg::t_mul_res o_res
);
    import pes_pkg::*;

    localparam int HW = QW / 2;
    localparam int PW = 2 * QW;

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_ACC  = 2'd1;
    localparam logic [1:0] M_RND  = 2'd2;

    logic [1:0]    r_state;
    logic [1:0]    r_cnt;
    logic [QW-1:0] r_ux;
    logic [QW-1:0] r_uy;
    logic          r_neg;
    logic [PW-1:0] r_acc;
    logic          r_done;
    logic          r_sat;
    t_q            r_prod;

    logic [QW-1:0]   abs_x;
    logic [QW-1:0]   abs_y;
    logic [HW-1:0]   x_half;
    logic [HW-1:0]   y_half;
    logic [2*HW-1:0] pp;
    logic [PW-1:0]   pp_sh;
    logic [PW-1:0]   rnd_mask;
    logic [PW-1:0]   q;
    logic [PW-1:0]   lim;
    logic            rem;
    logic            ovf;

    assign abs_x = i_x[QW-1] ? QW'(-i_x) : QW'(i_x);
    assign abs_y = i_y[QW-1] ? QW'(-i_y) : QW'(i_y);

    // r_cnt walks (lo,lo) (lo,hi) (hi,lo) (hi,hi)
    assign x_half = r_cnt[1] ? r_ux[QW-1:HW] : r_ux[HW-1:0];
    assign y_half = r_cnt[0] ? r_uy[QW-1:HW] : r_uy[HW-1:0];
    assign pp     = x_half * y_half;

    always_comb begin
        case (r_cnt) inside
            2'b00:        pp_sh = PW'(pp);
            2'b01, 2'b10: pp_sh = PW'(pp) << HW;
            default:      pp_sh = PW'(pp) << (2 * HW);
        endcase
    end

    // magnitude floor toward minus infinity: round up when negative and inexact
    assign rnd_mask = (PW'(1) << FRAC_BITS) - PW'(1);
    assign rem      = |(r_acc & rnd_mask);
    assign q        = (r_acc >> FRAC_BITS) + PW'(r_neg && rem);
    assign lim      = r_neg ? {{QW{1'b0}}, Q_MIN} : {{QW{1'b0}}, Q_MAX};
    assign ovf      = q > lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_state <= M_ACC;
                        r_cnt   <= '0;
                    end
                end
                M_ACC: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= M_RND;
                    end
                end
                M_RND: begin
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == M_IDLE && i_start) begin
            r_ux  <= abs_x;
            r_uy  <= abs_y;
            r_neg <= i_x[QW-1] ^ i_y[QW-1];
            r_acc <= '0;
        end else if (r_state == M_ACC) begin
            r_acc <= r_acc + pp_sh;
        end
        if (r_state == M_RND) begin
            r_sat <= ovf;
            if (ovf) begin
                r_prod <= r_neg ? Q_MIN : Q_MAX;
            end else begin
                r_prod <= r_neg ? -t_q'(q[QW-1:0]) : t_q'(q[QW-1:0]);
            end
        end
    end

    assign o_res = '{done: r_done, sat: r_sat, prod: r_prod};

endmodule

`default_nettype wire

@@ rtl/postfix_stack_evaluator.sv @@
// Postfix evaluator: one character word per cycle; result word the cycle after the last one.
// 'f' and 'g' hold the input over 4 multiplier steps, round, done flag, subtract and add,
// and a result that ends on them is pushed in the add step. Other characters: 1/cycle.
// Two-word result buffer; outside 'f'/'g' the input stalls only when the buffer is full.
// Reset (sync, active low) clears count, result and buffer, sets valid flag; stack is kept.
// Depends on pes_pkg, pes_if, pes_cell, pes_mulq.
`default_nettype none

module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pes_sym_if.sink          i_sym,
    pes_res_if.source        o_res
);
    import pes_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int EW = QW + 2;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_SUB  = 2'd2;
    localparam logic [1:0] S_ADD  = 2'd3;

    localparam logic [1:0] FIFO_FULL = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_valid, n_valid;
    t_q            r_lastres, n_lastres;
    logic          r_plast, n_plast;
    logic          r_pf, n_pf;
    t_q            r_s1;
    logic          r_s1sat;
    t_res          r_fifo [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_fcnt;

    t_q       stk_q [STACK_DEPTH];
    t_cell_op op_head, op_tail;
    t_q       head_d;

    t_op      dec_op;
    logic     in_acc;
    logic     push, pop;
    t_res     res_d;
    t_res     out_w;
    logic     mul_start;
    t_q       mul_y;
    t_mul_res mul_res;

    logic signed [EW-1:0] a_x, b_x, hb_x;
    logic signed [EW-1:0] trip_v, add_v, sub_v, alu_v, s1_v, s2_v;

    // ---------------- stack: row of cells, head at index 0 ----------------
    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        t_q       up_d, dn1_d, dn2_d;
        t_cell_op cop;

        if (gi == 0) begin : g_head
            assign up_d = head_d;
            assign cop  = op_head;
        end else begin : g_body
            assign up_d = stk_q[gi-1];
            assign cop  = op_tail;
        end
        if (gi + 1 < STACK_DEPTH) begin : g_dn1
            assign dn1_d = stk_q[gi+1];
        end else begin : g_dn1_end
            assign dn1_d = '0;
        end
        if (gi + 2 < STACK_DEPTH) begin : g_dn2
            assign dn2_d = stk_q[gi+2];
        end else begin : g_dn2_end
            assign dn2_d = '0;
        end

        pes_cell u_cell (
            .i_clk (i_clk),
            .i_op  (cop),
            .i_up  (up_d),
            .i_dn1 (dn1_d),
            .i_dn2 (dn2_d),
            .o_q   (stk_q[gi])
        );
    end

    // ---------------- multiplier ----------------
    assign mul_y = (dec_op == OP_F) ? stk_q[2] : stk_q[1];

    pes_mulq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mulq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (stk_q[2]),
        .i_y     (mul_y),
        .o_res   (mul_res)
    );

    // ---------------- decode and combinational arithmetic ----------------
    always_comb begin
        unique case (i_sym.symbol) inside
            [SYM_ZERO:SYM_NINE]: dec_op = OP_DIGIT;
            SYM_TRIPLE:          dec_op = OP_TRIPLE;
            SYM_ADD:             dec_op = OP_ADD;
            SYM_SUB:             dec_op = OP_SUB;
            SYM_F:               dec_op = OP_F;
            SYM_G:               dec_op = OP_G;
            default:             dec_op = OP_NONE;
        endcase
    end

    assign a_x    = EW'(stk_q[0]);
    assign b_x    = EW'(stk_q[1]);
    assign trip_v = (a_x <<< 1) + a_x;
    assign add_v  = b_x + a_x;
    assign sub_v  = b_x - a_x;
    assign alu_v  = (dec_op == OP_TRIPLE) ? trip_v :
                    (dec_op == OP_ADD)    ? add_v  : sub_v;

    // 'f' subtracts floor(b/2); 'g' has no middle term
    assign hb_x = r_pf ? EW'(stk_q[1] >>> 1) : '0;
    assign s1_v = EW'(mul_res.prod) - hb_x;
    assign s2_v = EW'(r_s1) + a_x;

    assign in_acc      = i_sym.valid && i_sym.ready;
    assign i_sym.ready = (r_state == S_IDLE) && (r_fcnt != FIFO_FULL);

    // ---------------- control ----------------
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_valid   = r_valid;
        n_lastres = r_lastres;
        n_plast   = r_plast;
        n_pf      = r_pf;
        op_head   = CELL_HOLD;
        op_tail   = CELL_HOLD;
        head_d    = stk_q[0];
        mul_start = 1'b0;
        push      = 1'b0;
        res_d     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_valid) begin
                        case (dec_op) inside
                            OP_DIGIT: begin
                                if (r_count >= CW'(STACK_DEPTH)) begin
                                    n_valid = 1'b0;
                                end else begin
                                    op_head = CELL_UP;
                                    op_tail = CELL_UP;
                                    head_d  = t_q'({{(QW-4){1'b0}}, i_sym.symbol[3:0]}
                                                   << FRAC_BITS);
                                    n_count = r_count + CW'(1);
                                end
                            end
                            OP_TRIPLE: begin
                                if (r_count < CW'(1) || q_ovf(alu_v)) begin
                                    n_valid = 1'b0;
                                end else begin
                                    op_head   = CELL_UP;
                                    head_d    = alu_v[QW-1:0];
                                    n_lastres = alu_v[QW-1:0];
                                end
                            end
                            OP_ADD, OP_SUB: begin
                                if (r_count < CW'(2) || q_ovf(alu_v)) begin
                                    n_valid = 1'b0;
                                end else begin
                                    op_head   = CELL_UP;
                                    op_tail   = CELL_DN1;
                                    head_d    = alu_v[QW-1:0];
                                    n_lastres = alu_v[QW-1:0];
                                    n_count   = r_count - CW'(1);
                                end
                            end
                            OP_F, OP_G: begin
                                if (r_count < CW'(3)) begin
                                    n_valid = 1'b0;
                                end else begin
                                    mul_start = 1'b1;
                                    n_state   = S_MUL;
                                    n_pf      = (dec_op == OP_F);
                                    n_plast   = i_sym.last;
                                end
                            end
                            default: ;
                        endcase
                    end
                    if (i_sym.last && !mul_start) begin
                        push      = 1'b1;
                        res_d     = '{ok:         n_valid && (n_count == CW'(1)),
                                      value:      n_lastres,
                                      depth_left: DEPTH_W'(n_count)};
                        n_count   = '0;
                        n_valid   = 1'b1;
                        n_lastres = '0;
                    end
                end
            end
            S_MUL: begin
                if (mul_res.done) begin
                    n_state = S_SUB;
                end
            end
            S_SUB: n_state = S_ADD;
            S_ADD: begin
                // any saturating stage kills the expression and leaves the stack alone
                if (mul_res.sat || r_s1sat || q_ovf(s2_v)) begin
                    n_valid = 1'b0;
                end else begin
                    op_head   = CELL_UP;
                    op_tail   = CELL_DN2;
                    head_d    = s2_v[QW-1:0];
                    n_lastres = s2_v[QW-1:0];
                    n_count   = r_count - CW'(2);
                end
                if (r_plast) begin
                    push      = 1'b1;
                    res_d     = '{ok:         n_valid && (n_count == CW'(1)),
                                  value:      n_lastres,
                                  depth_left: DEPTH_W'(n_count)};
                    n_count   = '0;
                    n_valid   = 1'b1;
                    n_lastres = '0;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_valid   <= 1'b1;
            r_lastres <= '0;
            r_plast   <= 1'b0;
            r_pf      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_valid   <= n_valid;
            r_lastres <= n_lastres;
            r_plast   <= n_plast;
            r_pf      <= n_pf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SUB) begin
            r_s1    <= s1_v[QW-1:0];
            r_s1sat <= q_ovf(s1_v);
        end
    end

    // ---------------- result buffer, two words ----------------
    assign pop = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt <= '0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_fcnt <= r_fcnt + 2'd1;
                2'b01:   r_fcnt <= r_fcnt - 2'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= res_d;
        end
    end

    assign out_w            = r_fifo[r_rp];
    assign o_res.valid      = (r_fcnt != 2'd0);
    assign o_res.ok         = out_w.ok;
    assign o_res.value      = out_w.value;
    assign o_res.depth_left = out_w.depth_left;

endmodule

`default_nettype wire

@@ rtl/pes_checker.sv @@
// pes_checker: port-level assertions for postfix_stack_evaluator, bound to the
// top level below. Depends on pes_pkg and the top level's interface ports.
`default_nettype none

module pes_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_last,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_ok,
    input pes_pkg::t_q                 i_out_value,
    input logic [pes_pkg::DEPTH_W-1:0] i_out_depth
);
    import pes_pkg::*;

    // expressions closed by a last word whose result word is not yet taken
    logic [2:0] r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 3'(i_in_valid && i_in_ready && i_in_last)
                             - 3'(i_out_valid && i_out_ready);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_ok) && $stable(i_out_value) && $stable(i_out_depth))
        else $error("result word changed while stalled");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 3'd0)
        else $error("result word without a closed expression");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd2)
        else $error("more closed expressions pending than buffer slots");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word present right after reset");

endmodule

bind postfix_stack_evaluator pes_checker u_pes_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sym.valid),
    .i_in_ready  (i_sym.ready),
    .i_in_last   (i_sym.last),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_ok    (o_res.ok),
    .i_out_value (o_res.value),
    .i_out_depth (o_res.depth_left)
);

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for postfix_stack_evaluator: streams postfix expressions over the
// symbol channel and checks each result word against an in-bench RPN evaluator.
// Depends on pes_pkg, pes_if and the evaluator RTL.

module tb;
    import pes_pkg::*;

    localparam int DEPTH       = 16;
    localparam int FRAC        = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;

    typedef logic signed [95:0] t_wide;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_sym_word;

    logic i_clk;
    logic i_rst_n;

    pes_sym_if sym_if ();
    pes_res_if res_if ();

    postfix_stack_evaluator #(
        .STACK_DEPTH (DEPTH),
        .FRAC_BITS   (FRAC)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sym   (sym_if),
        .o_res   (res_if)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // evaluator state
    t_q  rpn_stack [DEPTH];
    int  rpn_count;
    bit  rpn_valid;
    t_q  rpn_answer;

    t_res       expected_answers [$];
    t_sym_word  sym_words [$];
    logic [7:0] expr_chars [$];
    t_sym_word  next_word;
    t_res       got_answer;

    int errors;
    int words_made;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_go;
    int hold_left;
    int quiet_cycles;

    int send_pct_tab [4] = '{0, 72, 0, 31};
    int recv_pct_tab [4] = '{0, 0, 72, 31};

    function automatic t_q clamp_q(input t_wide v, inout bit sat);
        if (v > t_wide'(Q_MAX)) begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (v < t_wide'(Q_MIN)) begin
            sat = 1'b1;
            return Q_MIN;
        end
        return t_q'(v);
    endfunction

    // product floored to FRAC fraction bits
    function automatic t_q mul_floor(input t_q x, input t_q y, inout bit sat);
        t_wide p;
        p = t_wide'(x) * t_wide'(y);
        return clamp_q(p >>> FRAC, sat);
    endfunction

    task automatic rpn_clear();
        rpn_count  = 0;
        rpn_valid  = 1'b1;
        rpn_answer = '0;
    endtask

    task automatic rpn_apply(input logic [SYM_W-1:0] s);
        int need;
        t_q a, b, c, r;
        bit sat;
        need = 0;
        sat  = 1'b0;
        r    = '0;
        if (s >= SYM_ZERO && s <= SYM_NINE) begin
            if (rpn_count >= DEPTH) begin
                rpn_valid = 1'b0;
            end else begin
                rpn_stack[rpn_count] = t_q'(s - SYM_ZERO) << FRAC;
                rpn_count++;
            end
            return;
        end
        case (s)
            SYM_TRIPLE:       need = 1;
            SYM_ADD, SYM_SUB: need = 2;
            SYM_F, SYM_G:     need = 3;
            default:          return;
        endcase
        if (rpn_count < need) begin
            rpn_valid = 1'b0;
            return;
        end
        a = rpn_stack[rpn_count-1];
        b = (need >= 2) ? rpn_stack[rpn_count-2] : '0;
        c = (need >= 3) ? rpn_stack[rpn_count-3] : '0;
        case (s)
            SYM_TRIPLE: r = clamp_q(t_wide'(a) * 3, sat);
            SYM_ADD:    r = clamp_q(t_wide'(b) + t_wide'(a), sat);
            SYM_SUB:    r = clamp_q(t_wide'(b) - t_wide'(a), sat);
            SYM_F: begin
                r = mul_floor(c, c, sat);
                r = clamp_q(t_wide'(r) - (t_wide'(b) >>> 1), sat);
                r = clamp_q(t_wide'(r) + t_wide'(a), sat);
            end
            default: begin
                r = mul_floor(c, b, sat);
                r = clamp_q(t_wide'(r) + t_wide'(a), sat);
            end
        endcase
        // saturation leaves stack and answer untouched
        if (sat) begin
            rpn_valid = 1'b0;
            return;
        end
        rpn_count -= need;
        rpn_stack[rpn_count] = r;
        rpn_count++;
        rpn_answer = r;
    endtask

    task automatic rpn_take(input logic [SYM_W-1:0] s, input logic lst);
        t_res r;
        if (rpn_valid)
            rpn_apply(s);
        if (lst) begin
            r.ok         = rpn_valid && (rpn_count == 1);
            r.value      = rpn_answer;
            r.depth_left = DEPTH_W'(rpn_count);
            expected_answers.push_back(r);
            rpn_clear();
        end
    endtask

    // ---------------- expression generation ----------------

    task automatic add_chr(input logic [SYM_W-1:0] s);
        expr_chars.push_back(s);
    endtask

    task automatic add_str(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            add_chr(s[k]);
    endtask

    task automatic commit_expr();
        t_sym_word w;
        int k;
        for (k = 0; k < expr_chars.size(); k++) begin
            w.symbol = expr_chars[k];
            w.last   = (k == expr_chars.size() - 1);
            sym_words.push_back(w);
        end
        words_made += expr_chars.size();
        expr_chars.delete();
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(SYM_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_op(input int depth);
        logic [7:0] pick [$];
        pick.push_back(SYM_TRIPLE);
        if (depth >= 2) begin
            pick.push_back(SYM_ADD);
            pick.push_back(SYM_SUB);
        end
        if (depth >= 3) begin
            pick.push_back(SYM_F);
            pick.push_back(SYM_G);
        end
        return pick[$urandom_range(0, pick.size() - 1)];
    endfunction

    function automatic int op_pops(input logic [7:0] op);
        case (op)
            SYM_ADD, SYM_SUB: return 1;
            SYM_F, SYM_G:     return 2;
            default:          return 0;
        endcase
    endfunction

    task automatic reduce_to_one(inout int depth);
        while (depth > 1) begin
            if (depth >= 3 && $urandom_range(0, 1) == 1) begin
                add_chr($urandom_range(0, 1) ? SYM_F : SYM_G);
                depth -= 2;
            end else begin
                add_chr($urandom_range(0, 1) ? SYM_ADD : SYM_SUB);
                depth -= 1;
            end
        end
    endtask

    task automatic gen_wellformed();
        int depth, steps, k;
        logic [7:0] op;
        depth = 0;
        steps = $urandom_range(1, 16);
        for (k = 0; k < steps; k++) begin
            if (depth == 0 || (depth < DEPTH && $urandom_range(0, 9) < 4)) begin
                add_chr(rand_digit());
                depth++;
            end else begin
                op = rand_op(depth);
                add_chr(op);
                depth -= op_pops(op);
            end
            if ($urandom_range(0, 19) == 0)
                add_chr(8'($urandom_range(0, 255)));
        end
        reduce_to_one(depth);
    endtask

    // repeated halving, squaring and scaling of one accumulator on top of a few
    // spare digits: reaches deep fraction bits, negative floors and saturation
    task automatic gen_growth();
        int depth, rounds, k;
        depth = $urandom_range(1, 8);
        for (k = 0; k < depth; k++)
            add_chr(rand_digit());
        add_chr(rand_digit());
        depth++;
        if ($urandom_range(0, 2) == 0) begin
            add_chr(rand_digit());
            add_chr(SYM_SUB);
        end
        rounds = $urandom_range(3, 12);
        for (k = 0; k < rounds; k++) begin
            case ($urandom_range(0, 5))
                0: add_chr(SYM_TRIPLE);
                1: begin
                    if (depth >= 2) begin
                        add_chr(rand_digit());
                        add_chr(SYM_F);
                        depth--;
                    end
                end
                2: begin
                    add_chr(rand_digit());
                    add_chr(rand_digit());
                    add_chr(SYM_F);
                end
                3: begin
                    add_chr(rand_digit());
                    add_chr(rand_digit());
                    add_chr(SYM_G);
                end
                4: begin
                    add_chr(rand_digit());
                    add_chr($urandom_range(0, 1) ? SYM_ADD : SYM_SUB);
                end
                default: begin
                    if (depth >= 2) begin
                        add_chr(rand_digit());
                        add_chr(SYM_G);
                        depth--;
                    end
                end
            endcase
        end
        if ($urandom_range(0, 3) != 0)
            reduce_to_one(depth);
    endtask

    task automatic gen_broken();
        int k, n, depth;
        case ($urandom_range(0, 4))
            0: begin
                // push past a full stack
                n = DEPTH + $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    add_chr(rand_digit());
                n = $urandom_range(0, 3);
                for (k = 0; k < n; k++)
                    add_chr(SYM_ADD);
            end
            1: begin
                add_chr(rand_op(3));
                gen_wellformed();
            end
            2: begin
                n = $urandom_range(2, 6);
                for (k = 0; k < n; k++)
                    add_chr(rand_digit());
                if ($urandom_range(0, 1) == 1)
                    add_chr(rand_op(2));
            end
            3: begin
                gen_wellformed();
                add_chr(rand_op(3));
            end
            default: begin
                // exactly full, then folded down: still a valid expression
                for (k = 0; k < DEPTH; k++)
                    add_chr(rand_digit());
                depth = DEPTH;
                reduce_to_one(depth);
            end
        endcase
    endtask

    task automatic gen_noise();
        int k, n;
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
            add_chr(8'($urandom_range(0, 255)));
    endtask

    task automatic fill_random(input int n);
        int start, pick;
        start = words_made;
        while (words_made - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                gen_wellformed();
            else if (pick < 70)
                gen_growth();
            else if (pick < 90)
                gen_broken();
            else
                gen_noise();
            commit_expr();
        end
    endtask

    task automatic wait_drained();
        while (sym_words.size() != 0 || sym_if.valid)
            @(negedge i_clk);
        while (expected_answers.size() != 0)
            @(negedge i_clk);
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sym_if.valid <= 1'b0;
        end else begin
            if (sym_if.valid && sym_if.ready)
                rpn_take(sym_if.symbol, sym_if.last);
            if (!sym_if.valid || sym_if.ready) begin
                if (sym_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_word = sym_words.pop_front();
                    sym_if.valid  <= 1'b1;
                    sym_if.symbol <= next_word.symbol;
                    sym_if.last   <= next_word.last;
                end else begin
                    sym_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected result word ok=%0b value=%0d depth=%0d",
                             $time, res_if.ok, res_if.value, res_if.depth_left);
                    errors++;
                end else begin
                    got_answer = expected_answers.pop_front();
                    if (res_if.ok !== got_answer.ok) begin
                        $display("%0t: ok mismatch, expected %0b, got %0b",
                                 $time, got_answer.ok, res_if.ok);
                        errors++;
                    end
                    if (res_if.value !== got_answer.value) begin
                        $display("%0t: value mismatch, expected %0d, got %0d",
                                 $time, got_answer.value, res_if.value);
                        errors++;
                    end
                    if (res_if.depth_left !== got_answer.depth_left) begin
                        $display("%0t: depth_left mismatch, expected %0d, got %0d",
                                 $time, got_answer.depth_left, res_if.depth_left);
                        errors++;
                    end
                end
            end
            res_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n || (sym_if.valid && sym_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("[postfix_stack_evaluator] ERROR");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        int ph;
        i_rst_n        = 1'b0;
        sym_if.valid   = 1'b0;
        sym_if.symbol  = '0;
        sym_if.last    = 1'b0;
        res_if.ready   = 1'b0;
        hold_go        = 1'b0;
        hold_left      = 0;
        quiet_cycles   = 0;
        errors         = 0;
        words_made     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rpn_clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: lone digit, ignored bytes at both ends of the code range,
        // every operator, too few operands then ignored tail, and a squaring
        // chain that ends in a saturated product
        add_str("9");
        commit_expr();
        add_str("1x2+");
        add_chr(8'hFF);
        add_chr(8'h00);
        add_chr(SYM_TRIPLE);
        commit_expr();
        add_str("+1");
        commit_expr();
        add_str("576g03-4f00f00f");
        commit_expr();

        fill_random(170);
        // receiver holds off while words keep coming
        hold_go = 1'b1;
        @(negedge i_clk);
        hold_go = 1'b0;
        wait_drained();

        for (ph = 1; ph < 4; ph++) begin
            send_idle_pct  = send_pct_tab[ph];
            recv_stall_pct = recv_pct_tab[ph];
            fill_random(185);
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("[postfix_stack_evaluator] OK");
        else
            $display("[postfix_stack_evaluator] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pes_pkg.sv
rtl/pes_if.sv
rtl/pes_cell.sv
rtl/pes_mulq.sv
rtl/postfix_stack_evaluator.sv
rtl/pes_checker.sv
dv/tb.sv
